>>> hdl/json_tokenizer_defines.svh
// assertion macros used by the tokenizer back end (jtok_back)
`ifndef JSON_TOKENIZER_DEFINES_SVH
`define JSON_TOKENIZER_DEFINES_SVH

// implication checked at every rising clock edge outside reset
`define JT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define JT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/jtok_pkg.sv
// ----------------------------------------------------------------------------
// jtok_pkg
// types and constants shared by the tokenizer modules
// ----------------------------------------------------------------------------
package jtok_pkg;

   typedef struct packed {
      logic [15:0] char_code;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [7:0]  token_index;
      logic [1:0]  token_kind;
      logic [15:0] start_pos;
      logic [15:0] end_pos;
      logic [8:0]  child_count;
      logic [1:0]  status;
      logic        end_of_run;
   } rsp_type;

   localparam logic [1:0] EV_LEAF   = 2'd0;
   localparam logic [1:0] EV_CLOSE  = 2'd1;
   localparam logic [1:0] EV_STATUS = 2'd2;

   localparam logic [1:0] KIND_PRIM = 2'd0;
   localparam logic [1:0] KIND_STR  = 2'd1;
   localparam logic [1:0] KIND_OBJ  = 2'd2;
   localparam logic [1:0] KIND_ARR  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOMEM = 2'd1;
   localparam logic [1:0] ST_INVAL = 2'd2;
   localparam logic [1:0] ST_PART  = 2'd3;

   localparam logic CSR_STRICT = 1'b0;
   localparam logic CSR_LIMIT  = 1'b1;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_PRIM = 2'd1,
      MODE_STR  = 2'd2
   } mode_type;

   // character class produced by the front end
   typedef struct packed {
      logic open_c;      // { or [
      logic close_c;     // } or ]
      logic is_brk;      // [ or ]
      logic quote;
      logic bslash;
      logic sep;         // whitespace, comma, colon, 0xa0
      logic colon;
      logic ctrl;        // below 32 or at or above 127
      logic strict_ok;   // - 0-9 t f n
      logic esc_ok;
   } cls_type;

   typedef struct packed {
      cls_type     cls;
      logic        last;
   } qent_type;

endpackage

>>> hdl/json_tokenizer.sv
// path: an accepted item waits in the front queue, then its results are
//   registered in the output slots and leave them in order
// throughput: one character per cycle while the back end is free; a push or
//   pop of a container adds a bubble for the stack ram read, and items with
//   several results hold the back end until each extra result is taken
// reset: synchronous, active high; clears document state and registers
// ----------------------------------------------------------------------------
// json_tokenizer
// streaming json tokenizer, one utf-16 code unit per item
// ----------------------------------------------------------------------------
module json_tokenizer #(
   parameter int MAX_TOKENS    = 256,
   parameter int MAX_DEPTH     = 64,
   parameter int POSITION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  jtok_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output jtok_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [8:0]        csr_wdata
);
   import jtok_pkg::*;

   logic       strict_ff;
   logic [8:0] limit_ff;
   logic       q_valid, q_pop;
   qent_type   q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b0;
         limit_ff  <= 9'd256;
      end else if (csr_we) begin
         if (csr_index == CSR_STRICT) strict_ff <= csr_wdata[0];
         if (csr_index == CSR_LIMIT)  limit_ff  <= csr_wdata;
      end
   end

   jtok_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data));

   jtok_back #(.MAX_TOKENS(MAX_TOKENS), .MAX_DEPTH(MAX_DEPTH),
               .POSITION_BITS(POSITION_BITS)) u_back (
      .clock(clock), .reset(reset), .strict_mode(strict_ff), .token_limit(limit_ff),
      .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .rsp_data(rsp_data));
endmodule

>>> hdl/jtok_ram.sv
// ----------------------------------------------------------------------------
// jtok_ram
// generic single-port-write ram with registered read
// ----------------------------------------------------------------------------
module jtok_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

>>> hdl/jtok_front.sv
// ----------------------------------------------------------------------------
// jtok_front
// accepts characters, classifies them and pushes them into a short queue
// ----------------------------------------------------------------------------
module jtok_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  jtok_pkg::req_type      req_data,
   output logic                   q_valid,
   input  logic                   q_pop,
   output jtok_pkg::qent_type     q_data
);
   import jtok_pkg::*;

   localparam int QD = 2;

   qent_type    ent_ff [QD];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   qent_type    ent;
   logic [15:0] c;
   logic        push;

   always_comb begin
      c = req_data.char_code;
      ent.last = req_data.last;
      ent.cls.open_c  = (c == 16'h7b) || (c == 16'h5b);
      ent.cls.close_c = (c == 16'h7d) || (c == 16'h5d);
      ent.cls.is_brk  = (c == 16'h5b) || (c == 16'h5d);
      ent.cls.quote   = (c == 16'h22);
      ent.cls.bslash  = (c == 16'h5c);
      ent.cls.colon   = (c == 16'h3a);
      ent.cls.sep     = (c == 16'h09) || (c == 16'h0d) || (c == 16'h0a) ||
                        (c == 16'h20) || (c == 16'h2c) || (c == 16'h3a) ||
                        (c == 16'ha0);
      ent.cls.ctrl    = (c < 16'd32) || (c >= 16'd127);
      ent.cls.strict_ok = (c == 16'h2d) || ((c >= 16'h30) && (c <= 16'h39)) ||
                          (c == 16'h74) || (c == 16'h66) || (c == 16'h6e);
      ent.cls.esc_ok  = (c == 16'h22) || (c == 16'h2f) || (c == 16'h5c) ||
                        (c == 16'h62) || (c == 16'h66) || (c == 16'h72) ||
                        (c == 16'h6e) || (c == 16'h74) || (c == 16'h75);
   end

   assign req_ready = (cnt_ff != 2'(QD));
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = ent_ff[rp_ff];

   always_comb begin
      wp_in  = push  ? ~wp_ff : wp_ff;
      rp_in  = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         ent_ff[wp_ff] <= ent;
      end
   end
endmodule

>>> hdl/jtok_back.sv
// ----------------------------------------------------------------------------
// jtok_back
// tokenizer state, container stack and result output registers
// ----------------------------------------------------------------------------
`include "json_tokenizer_defines.svh"
module jtok_back #(
   parameter int MAX_TOKENS    = 256,
   parameter int MAX_DEPTH     = 64,
   parameter int POSITION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               strict_mode,
   input  logic [8:0]         token_limit,
   input  logic               q_valid,
   output logic               q_pop,
   input  jtok_pkg::qent_type q_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output jtok_pkg::rsp_type  rsp_data
);
   import jtok_pkg::*;

   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int TW = $clog2(MAX_TOKENS + 1);
   localparam int PW = POSITION_BITS;
   localparam int FW = 1 + TW + PW;      // is_array, index, start
   localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

   // document state
   logic [PW-1:0] pos_ff, pos_in;
   logic [TW-1:0] used_ff, used_in;
   mode_type      mode_ff, mode_in;
   logic          esc_ff, esc_in;
   logic [PW-1:0] istart_ff, istart_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic          err_ff, err_in;
   logic [1:0]    code_ff, code_in;

   // top frame cached in registers; ram holds frames below it
   logic [FW-1:0] top_ff, top_in;
   logic [8:0]    topcnt_ff, topcnt_in;
   // child counts of the frames below the top live in a second ram
   logic          ram_we, cnt_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [FW-1:0] ram_wd, ram_rd;
   logic [8:0]    cnt_wd, cnt_rd;

   // output slots
   rsp_type       slot_ff [3], slot_in [3];
   logic [1:0]    nres_ff, nres_in, sidx_ff, sidx_in;

   logic [TW-1:0] lim;
   logic          go;
   cls_type       k;
   logic          fire_delay_ff, fire_delay_in;

   assign lim = (32'(token_limit) < MAX_TOKENS) ? TW'(token_limit) : TW'(MAX_TOKENS);

   // a pop or push changes the prefetch; a bubble lets the ram read refill it
   assign rsp_valid = (nres_ff != 2'd0);
   assign rsp_data  = slot_ff[sidx_ff];
   assign go    = q_valid && (nres_ff == 2'd0 || (rsp_ready && (sidx_ff + 2'd1 == nres_ff)))
                  && !fire_delay_ff;
   assign q_pop = go;
   assign k     = q_data.cls;

   jtok_ram #(.WIDTH(FW), .DEPTH(MAX_DEPTH)) u_frames (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd));
   jtok_ram #(.WIDTH(9), .DEPTH(MAX_DEPTH)) u_counts (
      .clock(clock), .wr_en(cnt_we), .wr_addr(ram_wa), .wr_data(cnt_wd),
      .rd_addr(ram_ra), .rd_data(cnt_rd));

   always_comb begin
      logic [1:0]    n;
      logic [PW-1:0] epos;
      logic          allocok;
      logic          do_proc;
      logic          pushed, popped;
      rsp_type       r;

      pos_in = pos_ff; used_in = used_ff; mode_in = mode_ff; esc_in = esc_ff;
      istart_in = istart_ff; depth_in = depth_ff; err_in = err_ff; code_in = code_ff;
      top_in = top_ff; topcnt_in = topcnt_ff;
      ram_we = 1'b0; cnt_we = 1'b0; ram_wa = '0; ram_wd = top_ff; cnt_wd = topcnt_ff;
      // frame below top is read from ram at depth - 2
      ram_ra = (depth_ff >= DW'(2)) ? AW'(depth_ff - DW'(2)) : '0;
      n = 2'd0; r = '0; pushed = 1'b0; popped = 1'b0;
      for (int i = 0; i < 3; i++) slot_in[i] = slot_ff[i];
      nres_in = nres_ff; sidx_in = sidx_ff;
      fire_delay_in = 1'b0;
      epos = '0; allocok = 1'b0; do_proc = 1'b0;

      if (rsp_valid && rsp_ready) begin
         if (sidx_ff + 2'd1 == nres_ff) begin
            nres_in = 2'd0; sidx_in = 2'd0;
         end else begin
            sidx_in = sidx_ff + 2'd1;
         end
      end

      if (go) begin
         if (!err_ff) begin
            if (pos_ff >= POS_MAX) begin
               err_in = 1'b1; code_in = ST_NOMEM;
            end else if (mode_ff == MODE_STR) begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  if (!k.esc_ok) begin
                     err_in = 1'b1; code_in = ST_INVAL;
                  end
               end else if (k.quote) begin
                  mode_in = MODE_IDLE;
                  if (used_ff >= lim) begin
                     err_in = 1'b1; code_in = ST_NOMEM;
                  end else begin
                     r = '0; r.event_res = EV_LEAF; r.token_index = 8'(used_ff);
                     r.token_kind = KIND_STR; r.start_pos = 16'(istart_ff);
                     r.end_pos = 16'(pos_ff);
                     slot_in[n] = r; n = n + 2'd1;
                     used_in = used_ff + TW'(1);
                     if (depth_ff != '0) topcnt_in = topcnt_ff + 9'd1;
                  end
               end else if (k.bslash) begin
                  esc_in = 1'b1;
               end
            end else begin
               do_proc = 1'b1;
               if (mode_ff == MODE_PRIM) begin
                  if (!(k.sep && !(k.colon && strict_mode)) && !k.close_c) begin
                     do_proc = 1'b0;
                     if (k.ctrl) begin
                        err_in = 1'b1; code_in = ST_INVAL;
                     end
                  end else begin
                     mode_in = MODE_IDLE;
                     if (used_ff >= lim) begin
                        err_in = 1'b1; code_in = ST_NOMEM; do_proc = 1'b0;
                     end else begin
                        r = '0; r.event_res = EV_LEAF; r.token_index = 8'(used_ff);
                        r.token_kind = KIND_PRIM; r.start_pos = 16'(istart_ff);
                        r.end_pos = 16'(pos_ff);
                        slot_in[n] = r; n = n + 2'd1;
                        used_in = used_ff + TW'(1);
                        if (depth_ff != '0) topcnt_in = topcnt_ff + 9'd1;
                     end
                  end
               end
               if (do_proc) begin
                  if (k.open_c) begin
                     allocok = (used_in < lim);
                     if (!allocok) begin
                        err_in = 1'b1; code_in = ST_NOMEM;
                     end else begin
                        used_in = used_in + TW'(1);
                        if (depth_ff != '0) topcnt_in = topcnt_in + 9'd1;
                        if (depth_ff >= DW'(MAX_DEPTH)) begin
                           err_in = 1'b1; code_in = ST_NOMEM;
                        end else begin
                           // spill current top into ram
                           if (depth_ff != '0) begin
                              ram_we = 1'b1; cnt_we = 1'b1;
                              ram_wa = AW'(depth_ff - DW'(1));
                              ram_wd = top_ff; cnt_wd = topcnt_in;
                           end
                           top_in = {k.is_brk, TW'(used_in - TW'(1)), pos_ff};
                           topcnt_in = 9'd0;
                           depth_in = depth_ff + DW'(1);
                           pushed = 1'b1;
                        end
                     end
                  end else if (k.close_c) begin
                     if (depth_ff == '0 || top_ff[FW-1] != k.is_brk) begin
                        err_in = 1'b1; code_in = ST_INVAL;
                     end else begin
                        r = '0; r.event_res = EV_CLOSE;
                        r.token_index = 8'(top_ff[PW +: TW]);
                        r.token_kind = k.is_brk ? KIND_ARR : KIND_OBJ;
                        r.start_pos = 16'(top_ff[PW-1:0]);
                        r.end_pos = 16'(pos_ff + PW'(1));
                        r.child_count = topcnt_in;
                        slot_in[n] = r; n = n + 2'd1;
                        top_in = ram_rd; topcnt_in = cnt_rd;
                        depth_in = depth_ff - DW'(1);
                        popped = 1'b1;
                     end
                  end else if (k.quote) begin
                     mode_in = MODE_STR; esc_in = 1'b0;
                     istart_in = pos_ff + PW'(1);
                  end else if (k.sep) begin
                     // separator
                  end else if (strict_mode ? !k.strict_ok : k.ctrl) begin
                     err_in = 1'b1; code_in = ST_INVAL;
                  end else begin
                     mode_in = MODE_PRIM; istart_in = pos_ff;
                  end
               end
            end
            if (!err_in) pos_in = pos_ff + PW'(1);
         end
         if (q_data.last) begin
            epos = pos_in;
            if (!err_in) begin
               if (mode_in == MODE_PRIM) begin
                  if (strict_mode) begin
                     err_in = 1'b1; code_in = ST_PART;
                  end else if (used_in >= lim) begin
                     err_in = 1'b1; code_in = ST_NOMEM;
                  end else begin
                     r = '0; r.event_res = EV_LEAF; r.token_index = 8'(used_in);
                     r.token_kind = KIND_PRIM; r.start_pos = 16'(istart_in);
                     r.end_pos = 16'(pos_in);
                     slot_in[n] = r; n = n + 2'd1;
                     used_in = used_in + TW'(1);
                  end
               end else if (mode_in == MODE_STR) begin
                  err_in = 1'b1; code_in = ST_PART;
               end
               if (!err_in && depth_in != '0) begin
                  err_in = 1'b1; code_in = ST_PART;
               end
            end
            r = '0; r.event_res = EV_STATUS; r.end_pos = 16'(epos);
            r.child_count = 9'(used_in); r.status = err_in ? code_in : ST_OK;
            slot_in[n] = r; n = n + 2'd1;
            pos_in = '0; used_in = '0; mode_in = MODE_IDLE; esc_in = 1'b0;
            istart_in = '0; depth_in = '0; err_in = 1'b0; code_in = ST_OK;
            pushed = 1'b0; popped = 1'b0;
         end
         if (n != 2'd0) begin
            slot_in[n - 2'd1].end_of_run = 1'b1;
            nres_in = n; sidx_in = 2'd0;
         end
         // prefetch of frame below top changes: wait for ram read
         fire_delay_in = pushed || popped;
         if (pushed) ram_ra = AW'(depth_ff - DW'(1));
         if (popped) ram_ra = (depth_ff >= DW'(3)) ? AW'(depth_ff - DW'(3)) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; used_ff <= '0; mode_ff <= MODE_IDLE; esc_ff <= 1'b0;
         istart_ff <= '0; depth_ff <= '0; err_ff <= 1'b0; code_ff <= ST_OK;
         nres_ff <= 2'd0; sidx_ff <= 2'd0; fire_delay_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in; used_ff <= used_in; mode_ff <= mode_in; esc_ff <= esc_in;
         istart_ff <= istart_in; depth_ff <= depth_in; err_ff <= err_in;
         code_ff <= code_in; nres_ff <= nres_in; sidx_ff <= sidx_in;
         fire_delay_ff <= fire_delay_in;
      end
      top_ff <= top_in; topcnt_ff <= topcnt_in;
      for (int i = 0; i < 3; i++) slot_ff[i] <= slot_in[i];
   end

   `JT_ASSERT_IMP(a_pop_needs_valid, clock, reset, q_pop, q_valid, "pop without item")
   `JT_ASSERT_IMP(a_sidx_range, clock, reset, rsp_valid, sidx_ff < nres_ff, "slot index")
   `JT_ASSERT_IMP(a_bubble, clock, reset, fire_delay_ff, !q_pop, "pop during stack refill")
endmodule

>>> tb/tb_json_tokenizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_tokenizer
// feeds json text one code unit per item (directed rows, then random documents
// in strict and relaxed mode, small token limits, depth overflow) and checks
// every record against a predictor kept in the bench or a typed expected record
// ----------------------------------------------------------------------------
module tb_json_tokenizer;
   import jtok_pkg::*;

   localparam int         DEPTH_MAX = 64;
   localparam int         POS_MAX   = 65535;
   localparam int         IDLE_LIMIT = 5000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_index = CSR_STRICT;
   logic [8:0] csr_wdata = '0;

   json_tokenizer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- tokenizer predictor
   bit          strict_r;
   int unsigned limit_r;
   int unsigned pos, used, item_from, depth, err_code;
   mode_type    scan;
   bit          esc_wait, err_on;
   int unsigned frame_idx [DEPTH_MAX];
   bit          frame_arr [DEPTH_MAX];
   int unsigned frame_start [DEPTH_MAX];
   int unsigned frame_kids [DEPTH_MAX];

   rsp_type step_recs[$];
   rsp_type records_due[$];

   function automatic void doc_clear();
      pos = 0; used = 0; scan = MODE_IDLE; esc_wait = 0; item_from = 0;
      depth = 0; err_on = 0; err_code = ST_OK;
   endfunction

   function automatic void raise_err(int unsigned code);
      err_on = 1; err_code = code;
   endfunction

   function automatic void add_rec(logic [1:0] ev, int unsigned idx, logic [1:0] kind,
                                   int unsigned s, int unsigned e, int unsigned cnt,
                                   logic [1:0] st);
      rsp_type r;
      r.event_res = ev; r.token_index = idx[7:0]; r.token_kind = kind;
      r.start_pos = s[15:0]; r.end_pos = e[15:0]; r.child_count = cnt[8:0];
      r.status = st; r.end_of_run = 1'b0;
      step_recs.push_back(r);
   endfunction

   function automatic bit take_slot(output int unsigned idx);
      int unsigned lim;
      lim = (limit_r < 256) ? limit_r : 256;
      if (used >= lim) begin
         raise_err(ST_NOMEM);
         return 0;
      end
      idx = used++;
      return 1;
   endfunction

   function automatic void count_child();
      if (depth > 0) frame_kids[depth-1]++;
   endfunction

   function automatic void leaf_end(logic [1:0] kind, int unsigned e);
      int unsigned idx;
      if (!take_slot(idx)) return;
      add_rec(EV_LEAF, idx, kind, item_from, e, 0, ST_OK);
      count_child();
   endfunction

   function automatic bit is_sep(logic [15:0] c);
      return c == 16'h09 || c == 16'h0d || c == 16'h0a || c == 16'h20 ||
             c == 16'h2c || c == 16'ha0;
   endfunction

   function automatic void scan_char(logic [15:0] c);
      int unsigned idx;
      if (scan == MODE_STR) begin
         if (esc_wait) begin
            esc_wait = 0;
            if (!(c inside {16'h22, 16'h2f, 16'h5c, 16'h62, 16'h66, 16'h72, 16'h6e,
                            16'h74, 16'h75}))
               raise_err(ST_INVAL);
         end else if (c == 16'h22) begin
            leaf_end(KIND_STR, pos);
            scan = MODE_IDLE;
         end else if (c == 16'h5c) begin
            esc_wait = 1;
         end
         return;
      end
      if (scan == MODE_PRIM) begin
         // a primitive ends on a separator or closer; colon only when relaxed
         if (!(is_sep(c) || c == 16'h5d || c == 16'h7d || (c == 16'h3a && !strict_r))) begin
            if (c < 32 || c >= 127) raise_err(ST_INVAL);
            return;
         end
         leaf_end(KIND_PRIM, pos);
         scan = MODE_IDLE;
         if (err_on) return;
      end
      if (c == 16'h7b || c == 16'h5b) begin
         if (!take_slot(idx)) return;
         count_child();
         if (depth >= DEPTH_MAX) begin
            raise_err(ST_NOMEM);
            return;
         end
         frame_idx[depth] = idx; frame_arr[depth] = (c == 16'h5b);
         frame_start[depth] = pos; frame_kids[depth] = 0;
         depth++;
      end else if (c == 16'h7d || c == 16'h5d) begin
         if (depth == 0 || frame_arr[depth-1] != (c == 16'h5d)) begin
            raise_err(ST_INVAL);
            return;
         end
         add_rec(EV_CLOSE, frame_idx[depth-1], frame_arr[depth-1] ? KIND_ARR : KIND_OBJ,
                 frame_start[depth-1], (pos + 1) & POS_MAX, frame_kids[depth-1], ST_OK);
         depth--;
      end else if (c == 16'h22) begin
         scan = MODE_STR; esc_wait = 0; item_from = (pos + 1) & POS_MAX;
      end else if (is_sep(c) || c == 16'h3a) begin
      end else if (strict_r) begin
         if (c == 16'h2d || (c >= 16'h30 && c <= 16'h39) || c == 16'h74 ||
             c == 16'h66 || c == 16'h6e) begin
            scan = MODE_PRIM; item_from = pos;
         end else
            raise_err(ST_INVAL);
      end else begin
         if (c < 32 || c >= 127) begin
            raise_err(ST_INVAL);
            return;
         end
         scan = MODE_PRIM; item_from = pos;
      end
   endfunction

   // works out the records of one accepted item; typed rows replace all of them
   function automatic void predict_item(req_type r, bit use_typed, rsp_type typed);
      step_recs.delete();
      if (!err_on) begin
         if (pos >= POS_MAX) raise_err(ST_NOMEM);
         else scan_char(r.char_code);
         if (!err_on) pos = (pos + 1) & POS_MAX;
      end
      if (r.last) begin
         if (!err_on) begin
            if (scan == MODE_PRIM) begin
               if (strict_r) raise_err(ST_PART);
               else leaf_end(KIND_PRIM, pos);
            end else if (scan == MODE_STR)
               raise_err(ST_PART);
            if (!err_on && depth > 0) raise_err(ST_PART);
         end
         add_rec(EV_STATUS, 0, KIND_PRIM, 0, pos, used, err_on ? 2'(err_code) : ST_OK);
         doc_clear();
      end
      if (step_recs.size() > 0) step_recs[step_recs.size()-1].end_of_run = 1'b1;
      if (use_typed) step_recs = '{typed};
      foreach (step_recs[i]) records_due.push_back(step_recs[i]);
   endfunction

   // ---------------------------------------------------------------- driving
   int accepted, bad, n_leaf, n_close, n_status, idle_cycles, burst_left;
   bit stall_hold;

   task automatic send_item(req_type r, bit use_typed = 0, rsp_type typed = '0);
      int gap;
      if (burst_left > 0) begin
         gap = 0; burst_left--;
      end else begin
         gap = $urandom_range(1, 5); burst_left = $urandom_range(0, 20);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      accepted++;
      predict_item(r, use_typed, typed);
   endtask

   task automatic send_text(ref logic [15:0] txt[$]);
      req_type r;
      foreach (txt[i]) begin
         r.char_code = txt[i]; r.last = (i == txt.size() - 1);
         send_item(r);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (records_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [8:0] value);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_STRICT) strict_r = value[0];
      else limit_r = value;
   endtask

   // receiver: ready pattern rotates among always, random and sparse, plus one long hold-off
   int rx_cycle;
   always @(negedge clock) begin
      rx_cycle++;
      case ((rx_cycle / 64) % 3)
         0: rsp_ready <= !stall_hold;
         1: rsp_ready <= !stall_hold && ($urandom_range(0, 1) == 1);
         default: rsp_ready <= !stall_hold && ((rx_cycle % 4) == 0);
      endcase
   end

   initial begin
      stall_hold = 0;
      wait (accepted >= 40);
      stall_hold = 1;
      repeat (300) @(posedge clock);
      stall_hold = 0;
   end

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         case (rsp_data.event_res)
            EV_LEAF:  n_leaf++;
            EV_CLOSE: n_close++;
            default:  n_status++;
         endcase
         if (records_due.size() == 0) begin
            bad++;
            if (bad <= 10) $display("unexpected record %p", rsp_data);
         end else begin
            want = records_due.pop_front();
            if (rsp_data.event_res !== want.event_res ||
                rsp_data.token_index !== want.token_index ||
                rsp_data.token_kind !== want.token_kind ||
                rsp_data.start_pos !== want.start_pos ||
                rsp_data.end_pos !== want.end_pos ||
                rsp_data.child_count !== want.child_count ||
                rsp_data.status !== want.status ||
                rsp_data.end_of_run !== want.end_of_run) begin
               bad++;
               if (bad <= 10) $display("mismatch: expected %p got %p", want, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles = 0;
      else if (++idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired, %0d records outstanding", records_due.size());
         $display("[json_tokenizer] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- random text
   logic [15:0] doc[$];

   function automatic void put(string s);
      for (int i = 0; i < s.len(); i++) doc.push_back(16'(s[i]));
   endfunction

   function automatic void put_space();
      case ($urandom_range(0, 7))
         0: put(" ");
         1: put("\n");
         2: doc.push_back(16'ha0);
         3: put("\t");
         default: ;
      endcase
   endfunction

   function automatic void gen_value(int lvl);
      int kind, n;
      kind = $urandom_range(0, 9);
      put_space();
      if (lvl < 4 && kind < 4) begin
         put(kind < 2 ? "{" : "[");
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) begin
            if (i > 0) put(",");
            if (kind < 2) begin
               gen_value(99);
               put(":");
            end
            gen_value(lvl + 1);
         end
         put_space();
         put(kind < 2 ? "}" : "]");
      end else if (kind < 7 || lvl == 99) begin
         put("\"");
         n = $urandom_range(0, 4);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
               0: doc.push_back(16'($urandom_range(0, 65535)));
               1: begin
                  put("\\");
                  case ($urandom_range(0, 9))
                     0: put("q");
                     1: put("u");
                     2: put("n");
                     3: put("\"");
                     4: put("\\");
                     default: put("t");
                  endcase
               end
               default: doc.push_back(16'($urandom_range(97, 122)));
            endcase
         end
         put("\"");
      end else begin
         case ($urandom_range(0, 5))
            0: put("true");
            1: put("false");
            2: put("null");
            3: put("abc");
            default: begin
               if ($urandom_range(0, 1)) put("-");
               n = $urandom_range(1, 4);
               for (int i = 0; i < n; i++) doc.push_back(16'($urandom_range(48, 57)));
            end
         endcase
      end
      put_space();
   endfunction

   task automatic random_docs(int items);
      int sent, k;
      sent = 0;
      while (sent < items) begin
         doc.delete();
         gen_value(0);
         // a fifth of the documents get one character broken
         if ($urandom_range(0, 4) == 0) begin
            k = $urandom_range(0, doc.size() - 1);
            case ($urandom_range(0, 2))
               0: doc[k] = 16'($urandom_range(0, 65535));
               1: doc[k] = 16'h7f;
               default: doc.delete(k);
            endcase
         end
         if (doc.size() == 0) put(" ");
         send_text(doc);
         sent += doc.size();
      end
   endtask

   // ---------------------------------------------------------------- directed rows
   typedef struct {
      logic [15:0] ch;
      bit          last;
      bit          typed;
      rsp_type     want;
   } row_type;

   row_type rows[$];

   function automatic void add_row(logic [15:0] ch, bit last, bit typed = 0,
                                   logic [1:0] st = ST_OK, int unsigned e = 0,
                                   int unsigned cnt = 0);
      row_type w;
      w.ch = ch; w.last = last; w.typed = typed;
      w.want = '{EV_STATUS, 8'd0, KIND_PRIM, 16'd0, e[15:0], cnt[8:0], st, 1'b1};
      rows.push_back(w);
   endfunction

   initial begin
      req_type r;
      strict_r = 0; limit_r = 256;
      doc_clear();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // closer on an empty stack, lone separator, control code at start
      add_row(16'h7d, 1, 1, ST_INVAL, 0, 0);
      add_row(16'h20, 1, 1, ST_OK, 1, 0);
      add_row(16'h0000, 1, 1, ST_INVAL, 0, 0);
      // object holding a string with the top code unit and an array
      add_row(16'h7b, 0); add_row(16'h22, 0); add_row(16'hffff, 0);
      add_row(16'h5c, 0); add_row(16'h6e, 0); add_row(16'h22, 0);
      add_row(16'h3a, 0); add_row(16'h5b, 0); add_row(16'h78, 0);
      add_row(16'h2c, 0); add_row(16'h2d, 0); add_row(16'h5d, 0);
      add_row(16'h7d, 1);
      // bad escape, primitive running into the end, mismatched closer
      add_row(16'h22, 0); add_row(16'h5c, 0); add_row(16'h71, 1);
      add_row(16'h74, 0); add_row(16'h31, 1);
      add_row(16'h5b, 0); add_row(16'h7d, 1);
      // container left open
      add_row(16'h5b, 1, 1, ST_PART, 1, 1);
      foreach (rows[i]) begin
         r.char_code = rows[i].ch; r.last = rows[i].last;
         send_item(r, rows[i].typed, rows[i].want);
      end
      drain();

      csr_write(CSR_STRICT, 9'd1);
      csr_write(CSR_LIMIT, 9'd256);
      random_docs(20);
      drain();

      csr_write(CSR_STRICT, 9'd0);
      csr_write(CSR_LIMIT, 9'd3);
      random_docs(15);
      drain();

      csr_write(CSR_LIMIT, 9'd0);
      random_docs(5);
      drain();

      // nesting one level past the stack
      csr_write(CSR_LIMIT, 9'd256);
      doc.delete();
      repeat (DEPTH_MAX + 1) put("[");
      send_text(doc);
      drain();

      $display("%0d items sent: %0d leaf, %0d close and %0d status records seen",
               accepted, n_leaf, n_close, n_status);
      $display("covered strict and relaxed modes, token limits 0/3/256 and stack overflow");
      if (bad == 0)
         $display("[json_tokenizer] OK");
      else
         $display("[json_tokenizer] ERROR");
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/jtok_pkg.sv
hdl/jtok_ram.sv
hdl/jtok_front.sv
hdl/jtok_back.sv
hdl/json_tokenizer.sv
tb/tb_json_tokenizer.sv
